// ===== rtl/dqe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS query name encoder package
// Shared types and constants for the front end, command queue and writer.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int unsigned OFF_W      = 9;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]        DOT_CHAR   = 8'd46;
  localparam logic [7:0]        TERM_CHAR  = 8'd0;
  localparam logic [OFF_W-1:0]  HDR_LEN    = 9'd12;
  localparam logic [OFF_W-1:0]  NAME_START = 9'd13;

  // Write slots of one item, in emission order.
  localparam logic [SLOT_W-1:0] SLOT_HDR_FIRST = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR_LAST  = 5'd11;
  localparam logic [SLOT_W-1:0] SLOT_LEN       = 5'd12;
  localparam logic [SLOT_W-1:0] SLOT_CHAR      = 5'd13;
  localparam logic [SLOT_W-1:0] SLOT_TYPE_HI   = 5'd14;
  localparam logic [SLOT_W-1:0] SLOT_TYPE_LO   = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_CLASS_HI  = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_CLASS_LO  = 5'd17;
  localparam logic [SLOT_W-1:0] SLOT_OVF       = 5'd18;

  localparam logic [0:0] CFG_QUERY_ID      = 1'b0;
  localparam logic [0:0] CFG_QUESTION_TYPE = 1'b1;

  typedef struct packed {
    logic             hdr;
    logic             len_write;
    logic [OFF_W-1:0] len_offset;
    logic [7:0]       len_value;
    logic [OFF_W-1:0] pos;
    logic [7:0]       ch;
    logic             term;
    logic             ovf;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dqe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS query name encoder front end
// Accepts name characters, tracks label positions and issues write commands.
// ----------------------------------------------------------------------------
module dqe_front #(
  parameter int unsigned MAX_NAME = 255
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    host_char,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output dqe_pkg::cmd_t      cmd
);
  import dqe_pkg::*;

  localparam logic [OFF_W-1:0] NAME_LIMIT = OFF_W'(MAX_NAME - 1);

  logic             in_name;
  logic [OFF_W-1:0] head_offset;
  logic [OFF_W-1:0] write_position;
  logic             is_sep;
  logic             is_term;
  logic             ovf;
  logic [7:0]       len_full;

  assign is_term  = (host_char == TERM_CHAR);
  assign is_sep   = is_term || (host_char == DOT_CHAR);
  assign ovf      = !is_term && in_name && ((write_position - NAME_START) >= NAME_LIMIT);
  assign len_full = 8'(write_position - head_offset - 9'd1);

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    cmd.hdr        = !ovf && !in_name;
    cmd.len_write  = !ovf && is_sep;
    cmd.len_offset = head_offset;
    cmd.len_value  = len_full;
    cmd.pos        = write_position;
    cmd.ch         = host_char;
    cmd.term       = !ovf && is_term;
    cmd.ovf        = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_name        <= 1'b0;
      head_offset    <= HDR_LEN;
      write_position <= NAME_START;
    end else if (in_valid && cmd_ready && !ovf) begin
      if (is_term) begin
        in_name        <= 1'b0;
        head_offset    <= HDR_LEN;
        write_position <= NAME_START;
      end else begin
        in_name        <= 1'b1;
        write_position <= write_position + 9'd1;
        if (is_sep) begin
          head_offset <= write_position;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dqe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS query name encoder command queue
// Small first-in first-out buffer between the front end and the writer.
// ----------------------------------------------------------------------------
module dqe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  dqe_pkg::cmd_t      push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output dqe_pkg::cmd_t      pop_cmd
);
  import dqe_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dqe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS query name encoder writer
// Walks each command's write slots, one byte write per cycle unless stalled.
// ----------------------------------------------------------------------------
module dqe_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cmd_valid,
  output logic                           cmd_ready,
  input  dqe_pkg::cmd_t                  cmd,
  input  wire logic [15:0]               query_id,
  input  wire logic [15:0]               question_type,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           write_valid,
  output logic [dqe_pkg::OFF_W-1:0]      write_offset,
  output logic [7:0]                     write_value,
  output logic                           last_of_run,
  output logic                           packet_done,
  output logic                           name_overflow
);
  import dqe_pkg::*;

  logic              active;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] nxt_slot;
  logic              finish;
  logic              load;
  logic [OFF_W-1:0]  offset_next;
  logic [7:0]        value_next;

  always_comb begin
    if (cmd.ovf) begin
      start_slot = SLOT_OVF;
    end else if (cmd.hdr) begin
      start_slot = SLOT_HDR_FIRST;
    end else if (cmd.len_write) begin
      start_slot = SLOT_LEN;
    end else begin
      start_slot = SLOT_CHAR;
    end
  end

  assign cur_slot = active ? slot : start_slot;

  always_comb begin
    nxt_slot = cur_slot + 5'd1;
    finish   = 1'b0;
    if (cur_slot == SLOT_OVF || cur_slot == SLOT_CLASS_LO) begin
      finish = 1'b1;
    end else if (cur_slot == SLOT_HDR_LAST) begin
      nxt_slot = cmd.len_write ? SLOT_LEN : SLOT_CHAR;
    end else if (cur_slot == SLOT_CHAR) begin
      finish = !cmd.term;
    end
  end

  always_comb begin
    offset_next = OFF_W'(cur_slot);
    value_next  = 8'h00;
    case (cur_slot)
      5'd0:          value_next = query_id[15:8];
      5'd1:          value_next = query_id[7:0];
      5'd2:          value_next = 8'h01;
      5'd5:          value_next = 8'h01;
      SLOT_LEN: begin
        offset_next = cmd.len_offset;
        value_next  = cmd.len_value;
      end
      SLOT_CHAR: begin
        offset_next = cmd.pos;
        value_next  = cmd.ch;
      end
      SLOT_TYPE_HI: begin
        offset_next = cmd.pos + 9'd1;
        value_next  = question_type[15:8];
      end
      SLOT_TYPE_LO: begin
        offset_next = cmd.pos + 9'd2;
        value_next  = question_type[7:0];
      end
      SLOT_CLASS_HI: begin
        offset_next = cmd.pos + 9'd3;
      end
      SLOT_CLASS_LO: begin
        offset_next = cmd.pos + 9'd4;
        value_next  = 8'h01;
      end
      SLOT_OVF: begin
        offset_next = '0;
      end
      default: begin
        offset_next = OFF_W'(cur_slot);
      end
    endcase
  end

  assign load      = cmd_valid && (!out_valid || out_ready);
  assign cmd_ready = load && finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        active    <= !finish;
        slot      <= nxt_slot;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      write_valid   <= (cur_slot != SLOT_OVF);
      write_offset  <= offset_next;
      write_value   <= value_next;
      last_of_run   <= finish;
      packet_done   <= (cur_slot == SLOT_CLASS_LO);
      name_overflow <= (cur_slot == SLOT_OVF);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dns_query_name_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS query name encoder
// Turns a zero-terminated dotted host name into DNS query packet byte writes.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// input    in_valid / in_ready   host_char
// output   out_valid / out_ready write_valid, write_offset, write_value,
//                                last_of_run, packet_done, name_overflow
// config   cfg_we                cfg_index, cfg_wdata
//
// The writer emits one byte write per cycle while the output is not stalled;
// an item causes one write for a plain character, two for a dot, six for a
// terminator, thirteen or fourteen for the first character of a name and
// eighteen for a terminator that arrives with no name started.
// A four-entry command queue lets the front end keep taking items while the
// writer works and while a result waits at the output register.
// Reset is synchronous and clears the name state, the queue and the output.
// ----------------------------------------------------------------------------
module dns_query_name_encoder_unit #(
  parameter int unsigned MAX_NAME = 255
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [15:0]               cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                host_char,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           write_valid,
  output logic [dqe_pkg::OFF_W-1:0]      write_offset,
  output logic [7:0]                     write_value,
  output logic                           last_of_run,
  output logic                           packet_done,
  output logic                           name_overflow
);
  import dqe_pkg::*;

  logic [15:0] query_id;
  logic [15:0] question_type;
  cmd_t        front_cmd;
  cmd_t        queue_cmd;
  logic        front_valid;
  logic        front_ready;
  logic        queue_valid;
  logic        queue_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_id      <= 16'd0;
      question_type <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_ID:      query_id      <= cfg_wdata;
        CFG_QUESTION_TYPE: question_type <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dqe_front #(
    .MAX_NAME (MAX_NAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .host_char (host_char),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  dqe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  dqe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (queue_valid),
    .cmd_ready     (queue_ready),
    .cmd           (queue_cmd),
    .query_id      (query_id),
    .question_type (question_type),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_valid   (write_valid),
    .write_offset  (write_offset),
    .write_value   (write_value),
    .last_of_run   (last_of_run),
    .packet_done   (packet_done),
    .name_overflow (name_overflow)
  );

endmodule
`default_nettype wire

// ===== sim/tb_dns_query_name_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query name encoder testbench
// Streams host names into the encoder under varying handshake pressure and
// checks every packet byte write against a cycle-free prediction of the
// header, the label-length fixups, the name bytes, the question trailer and
// the handling of names that run past the length limit.
// ----------------------------------------------------------------------------
module tb_dns_query_name_encoder_unit;
  import dqe_pkg::*;

  localparam int unsigned NAME_LIMIT    = 255;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned HOLD_STRETCH  = 300;
  localparam logic [15:0] FLAGS_RD      = 16'h0100;
  localparam logic [15:0] QDCOUNT_ONE   = 16'h0001;
  localparam logic [15:0] QCLASS_IN     = 16'h0001;

  typedef struct packed {
    logic             wr_valid;
    logic [OFF_W-1:0] offset;
    logic [7:0]       byte_val;
    logic             last_wr;
    logic             done;
    logic             ovf;
  } pkt_write_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = CFG_QUERY_ID;
  logic [15:0]      cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [7:0]       host_char = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             write_valid;
  logic [OFF_W-1:0] write_offset;
  logic [7:0]       write_value;
  logic             last_of_run;
  logic             packet_done;
  logic             name_overflow;

  dns_query_name_encoder_unit #(
    .MAX_NAME(NAME_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .host_char(host_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .write_valid(write_valid),
    .write_offset(write_offset),
    .write_value(write_value),
    .last_of_run(last_of_run),
    .packet_done(packet_done),
    .name_overflow(name_overflow)
  );

  logic [15:0]      id_shadow   = '0;
  logic [15:0]      type_shadow = 16'h0001;
  logic             name_open   = 1'b0;
  logic [OFF_W-1:0] label_head  = HDR_LEN;
  logic [OFF_W-1:0] name_pos    = NAME_START;

  pkt_write_t  pending_writes[$];
  logic [7:0]  host_fifo[$];
  int unsigned send_idle_pct  = 25;
  int unsigned recv_idle_pct  = 72;
  int unsigned hold_cycles    = 0;
  int unsigned chars_queued   = 0;
  int unsigned chars_accepted = 0;
  int unsigned writes_checked = 0;
  int unsigned packets_seen   = 0;
  int unsigned drops_seen     = 0;
  int unsigned reg_writes     = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  always #4 clk = ~clk;

  function automatic void push_write(input logic [OFF_W-1:0] off, input logic [7:0] val,
                                     input logic wv, input logic done, input logic ovf);
    pkt_write_t w;
    w = '{wr_valid: wv, offset: off, byte_val: val, last_wr: 1'b0, done: done, ovf: ovf};
    pending_writes.push_back(w);
  endfunction

  function automatic void predict_char(input logic [7:0] c);
    logic [95:0]      hdr_bytes;
    logic [OFF_W-1:0] label_len;
    int               i;
    if (c != TERM_CHAR && name_open &&
        int'(name_pos) - int'(NAME_START) >= int'(NAME_LIMIT) - 1) begin
      push_write('0, '0, 1'b0, 1'b0, 1'b1);
    end else begin
      if (!name_open) begin
        hdr_bytes = {id_shadow, FLAGS_RD, QDCOUNT_ONE, 48'd0};
        for (i = 0; i < 12; i++) begin
          push_write(OFF_W'(i), hdr_bytes[95 - 8 * i -: 8], 1'b1, 1'b0, 1'b0);
        end
        name_open  = 1'b1;
        label_head = HDR_LEN;
        name_pos   = NAME_START;
      end
      if (c == DOT_CHAR || c == TERM_CHAR) begin
        label_len = name_pos - label_head - 9'd1;
        push_write(label_head, label_len[7:0], 1'b1, 1'b0, 1'b0);
        label_head = name_pos;
      end
      push_write(name_pos, c, 1'b1, 1'b0, 1'b0);
      name_pos = name_pos + 9'd1;
      if (c == TERM_CHAR) begin
        push_write(name_pos, type_shadow[15:8], 1'b1, 1'b0, 1'b0);
        push_write(name_pos + 9'd1, type_shadow[7:0], 1'b1, 1'b0, 1'b0);
        push_write(name_pos + 9'd2, QCLASS_IN[15:8], 1'b1, 1'b0, 1'b0);
        push_write(name_pos + 9'd3, QCLASS_IN[7:0], 1'b1, 1'b1, 1'b0);
        name_open  = 1'b0;
        label_head = HDR_LEN;
        name_pos   = NAME_START;
      end
    end
    pending_writes[pending_writes.size() - 1].last_wr = 1'b1;
  endfunction

  // The prediction is made when an item is first offered, which is safe
  // because items are accepted strictly in order.
  always @(posedge clk) begin
    logic [7:0] c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) chars_accepted++;
      if (host_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = host_fifo.pop_front();
        predict_char(c);
        host_char <= c;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pkt_write_t want;
    pkt_write_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{wr_valid: write_valid, offset: write_offset, byte_val: write_value,
              last_wr: last_of_run, done: packet_done, ovf: name_overflow};
      writes_checked++;
      if (packet_done) packets_seen++;
      if (name_overflow) drops_seen++;
      if (pending_writes.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("unexpected write %0d: valid=%0d off=%0d val=%02h last=%0d done=%0d ovf=%0d",
                   writes_checked, got.wr_valid, got.offset, got.byte_val, got.last_wr,
                   got.done, got.ovf);
        end
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        if (got.wr_valid !== want.wr_valid || got.offset !== want.offset ||
            got.byte_val !== want.byte_val || got.last_wr !== want.last_wr ||
            got.done !== want.done || got.ovf !== want.ovf) begin
          if (fail_count < MAX_REPORTS) begin
            $write("write %0d mismatch: expected valid=%0d off=%0d val=%02h",
                   writes_checked, want.wr_valid, want.offset, want.byte_val);
            $display(" last=%0d done=%0d ovf=%0d", want.last_wr, want.done, want.ovf);
            $write("                    actual   valid=%0d off=%0d val=%02h",
                   got.wr_valid, got.offset, got.byte_val);
            $display(" last=%0d done=%0d ovf=%0d", got.last_wr, got.done, got.ovf);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d writes outstanding.",
               cycle_count, pending_writes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c);
    while (host_fifo.size() >= 2) @(negedge clk);
    host_fifo.push_back(c);
    chars_queued++;
  endtask

  task automatic send_name(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(TERM_CHAR);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (host_fifo.size() != 0 || in_valid || pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_QUERY_ID) id_shadow = data;
    else type_shadow = data;
    reg_writes++;
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    if ($urandom_range(3) == 0) begin
      b = 8'($urandom_range(1, 255));
      if (b == DOT_CHAR) b = 8'h2d;
    end else begin
      b = 8'h61 + 8'($urandom_range(25));
    end
    return b;
  endfunction

  task automatic send_random_name();
    int unsigned kind;
    int unsigned labels;
    int unsigned len;
    int unsigned l;
    kind = $urandom_range(9);
    if (kind == 1) begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        if ($urandom_range(3) == 0) send_char(DOT_CHAR);
        else send_char(8'($urandom_range(1, 255)));
      end
    end else if (kind != 0) begin
      labels = $urandom_range(1, 4);
      for (l = 0; l < labels; l++) begin
        if (l != 0) send_char(DOT_CHAR);
        len = $urandom_range(1, 15);
        repeat (len) send_char(name_byte());
      end
    end
    send_char(TERM_CHAR);
  endtask

  task automatic test_directed();
    send_char(TERM_CHAR);
    send_char(8'h01);
    send_char(8'hff);
    send_char(8'h80);
    send_char(8'h7f);
    send_name(".z");
    send_name("..x.");
    wait_idle();
    write_reg(CFG_QUERY_ID, 16'hffff);
    write_reg(CFG_QUESTION_TYPE, 16'hffff);
    send_char(TERM_CHAR);
    send_name("q");
    wait_idle();
    write_reg(CFG_QUERY_ID, 16'h0000);
    write_reg(CFG_QUESTION_TYPE, 16'h0000);
    send_name("a");
    wait_idle();
  endtask

  // One label filling the whole name, then dropped bytes including a dot.
  task automatic test_overflow();
    write_reg(CFG_QUERY_ID, 16'h1234);
    write_reg(CFG_QUESTION_TYPE, 16'h001c);
    repeat (NAME_LIMIT - 1) send_char(name_byte());
    send_char(8'h61);
    send_char(DOT_CHAR);
    send_char(8'hff);
    send_char(8'h01);
    send_char(TERM_CHAR);
    wait_idle();
  endtask

  task automatic test_random_names(input int unsigned count, input int unsigned snd_idle,
                                   input int unsigned rcv_idle);
    int unsigned start;
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    write_reg(CFG_QUERY_ID, 16'($urandom_range(16'hffff)));
    write_reg(CFG_QUESTION_TYPE, 16'($urandom_range(16'hffff)));
    start = chars_queued;
    while (chars_queued - start < count) send_random_name();
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_QUESTION_TYPE, 16'h0001);
    hold_cycles = HOLD_STRETCH;
    repeat (12) send_char(name_byte());
    send_char(TERM_CHAR);
    wait_idle();
    repeat (4) send_char(name_byte());
    send_char(TERM_CHAR);
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random_names(12, 25, 72);
    test_random_names(12, 72, 25);
    test_random_names(12, 0, 0);
    test_backpressure();
    if (pending_writes.size() != 0) begin
      $display("%0d expected writes never arrived.", pending_writes.size());
      fail_count++;
    end
    $display("Sent %0d characters; checked %0d writes, %0d packets and %0d dropped characters.",
             chars_accepted, writes_checked, packets_seen, drops_seen);
    $display("Used %0d register writes, three idle mixes and a %0d-cycle output hold.",
             reg_writes, HOLD_STRETCH);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures.", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
